[design/periodic_cell_list_overlap_search_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic cell list overlap search block
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_CELL_LIST_OVERLAP_SEARCH_MACROS_SVH
`define PERIODIC_CELL_LIST_OVERLAP_SEARCH_MACROS_SVH

// Check that cons holds in the cycle where ante holds
`define PCLO_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Check that cons holds in the cycle after ante holds
`define PCLO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[design/pclo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclo_pkg
// Types, constants and helper functions shared by the overlap search block.
// ----------------------------------------------------------------------------
package pclo_pkg;

	localparam int MAX_PARTICLES      = 4096;
	localparam int SLOT_W             = $clog2(MAX_PARTICLES);
	localparam int MAX_CELLS_PER_SIDE = 15;
	localparam int CELL_W             = 4;
	localparam int CELL_SLOTS         = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE
		* MAX_CELLS_PER_SIDE;
	localparam int CELL_AW            = $clog2(CELL_SLOTS);
	localparam int POSITION_BITS      = 20;
	localparam int LEN_W              = 32;
	localparam int CFG_IDX_W          = 3;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_CLEAR  = 2'd0;
	localparam opcode_t OP_INSERT = 2'd1;
	localparam opcode_t OP_QUERY  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SMALLEST = 3'd6;

	typedef struct packed {
		opcode_t                  opcode;
		logic [SLOT_W-1:0]        particle_index;
		logic [POSITION_BITS-1:0] pos_x;
		logic [POSITION_BITS-1:0] pos_y;
		logic [POSITION_BITS-1:0] pos_z;
		logic [LEN_W-1:0]         cutoff_distance;
	} in_item_t;

	typedef struct packed {
		logic    overlap_found;
		opcode_t done_opcode;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cap_in;
		logic clr_write;
		logic calc_cell;
		logic lin1;
		logic lin_scan;
		logic lin2;
		logic head_rd;
		logic ins_write;
		logic reach_init;
		logic reach_step;
		logic scan_init;
		logic wrap;
		logic cur_load;
		logic cur_next;
		logic node_rd;
		logic node_mul;
		logic node_sq;
		logic set_found;
		logic advance;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		opcode_t op;
		logic    sweep_last;
		logic    reach_done;
		logic    cheb_ok;
		logic    head_valid;
		logic    hit;
		logic    walk_more;
		logic    scan_last;
	} sts_t;

	function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] n);
		return (n < 4'd3) ? 4'd3 : n;
	endfunction

	function automatic logic [CELL_W-1:0] cell_of(input logic [POSITION_BITS-1:0] pos,
		input logic [CELL_W-1:0] n);
		logic [POSITION_BITS+CELL_W-1:0] p;
		p = {{CELL_W{1'b0}}, pos} * {{POSITION_BITS{1'b0}}, n};
		return p[POSITION_BITS+CELL_W-1:POSITION_BITS];
	endfunction

	// Periodic wrap of a cell coordinate plus a signed offset
	function automatic logic [CELL_W-1:0] wrap_coord(input logic [CELL_W-1:0] c,
		input logic signed [CELL_W:0] off, input logic [CELL_W-1:0] n);
		logic [CELL_W+1:0] s;
		logic [CELL_W+1:0] n1;
		logic [CELL_W+1:0] n2;
		n1 = {2'b00, n};
		n2 = {1'b0, n, 1'b0};
		s = {2'b00, c} + {off[CELL_W], off} + n1;
		if (s >= n2) begin
			s = s - n2;
		end else if (s >= n1) begin
			s = s - n1;
		end
		return s[CELL_W-1:0];
	endfunction

	function automatic logic [CELL_W-1:0] off_mag(input logic signed [CELL_W:0] v);
		logic [CELL_W:0] neg;
		neg = -v;
		return v[CELL_W] ? neg[CELL_W-1:0] : v[CELL_W-1:0];
	endfunction

	// Minimum-image component length, Q16.16, truncated
	function automatic logic [LEN_W-1:0] comp_len(input logic [POSITION_BITS-1:0] a,
		input logic [POSITION_BITS-1:0] b, input logic [LEN_W-1:0] len);
		logic [POSITION_BITS-1:0]       d;
		logic [POSITION_BITS:0]         wide;
		logic [POSITION_BITS-1:0]       mag;
		logic [POSITION_BITS+LEN_W-1:0] p;
		d = a - b;
		wide = {1'b1, {POSITION_BITS{1'b0}}} - {1'b0, d};
		mag = d[POSITION_BITS-1] ? wide[POSITION_BITS-1:0] : d;
		p = {{LEN_W{1'b0}}, mag} * {{POSITION_BITS{1'b0}}, len};
		return p[POSITION_BITS+LEN_W-1:POSITION_BITS];
	endfunction

endpackage

[design/pclo_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclo_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module pclo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/pclo_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclo_dp
// Datapath: configuration registers, cell index math, search counters, the
// head/link/position memories and the distance pipeline.
// ----------------------------------------------------------------------------
module pclo_dp import pclo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  in_item_t             in_item,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	output out_item_t            out_item
);

	localparam int HEAD_W = SLOT_W + 1;
	localparam int POS3_W = 3 * POSITION_BITS;
	localparam int KMUL_W = LEN_W + 4;
	localparam int SQ_W   = 2 * LEN_W;

	logic [CELL_W-1:0] cells_x_q, cells_y_q, cells_z_q;
	logic [LEN_W-1:0]  box_x_q, box_y_q, box_z_q, smallest_q;

	in_item_t          item_q;
	logic              found_q;
	out_item_t         out_q;
	logic [CELL_W-1:0] cx_q, cy_q, cz_q;
	logic [SQ_W-1:0]   csq_q;
	logic [2:0]        k_q, reach_q;
	logic [KMUL_W-1:0] kmul_q;
	logic signed [CELL_W:0] dx_q, dy_q, dz_q;
	logic [CELL_W-1:0] wx_q, wy_q, wz_q;
	logic              cheb_q;
	logic [7:0]        t_q;
	logic [CELL_AW-1:0] idx_q;
	logic [CELL_AW-1:0] sweep_q;
	logic [SLOT_W-1:0] cur_q, steps_q;
	logic [LEN_W-1:0]  mx_s1, my_s1, mz_s1;
	logic [SQ_W-1:0]   sx_s2, sy_s2, sz_s2;

	logic [CELL_W-1:0] nx, ny, nz, nmax, hx, hy, hz;
	logic [2:0]        maxshell;
	logic              shell_cap;
	logic [CELL_W-1:0] lx, ly, lz, amax;
	logic [HEAD_W-1:0] head_rdata, link_rdata, head_wdata;
	logic [POS3_W-1:0] pos_rdata;
	logic [CELL_AW-1:0] head_waddr;
	logic [SQ_W+1:0]   dsq;

	// Effective cell counts and search shell limit
	always_comb begin
		nx = eff_cells(cells_x_q);
		ny = eff_cells(cells_y_q);
		nz = eff_cells(cells_z_q);
		nmax = (nx > ny) ? nx : ny;
		if (nz > nmax) begin
			nmax = nz;
		end
		maxshell = 3'((nmax - 4'd1) >> 1);
		hx = nx >> 1;
		hy = ny >> 1;
		hz = nz >> 1;
		shell_cap = (smallest_q == '0) || (({1'b0, k_q} + 4'd1) >= {1'b0, maxshell});
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q  <= 4'd3;
			cells_y_q  <= 4'd3;
			cells_z_q  <= 4'd3;
			box_x_q    <= 32'd65536;
			box_y_q    <= 32'd65536;
			box_z_q    <= 32'd65536;
			smallest_q <= 32'd21845;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CELLS_X:  cells_x_q  <= cfg_data[CELL_W-1:0];
				CFG_CELLS_Y:  cells_y_q  <= cfg_data[CELL_W-1:0];
				CFG_CELLS_Z:  cells_z_q  <= cfg_data[CELL_W-1:0];
				CFG_BOX_X:    box_x_q    <= cfg_data;
				CFG_BOX_Y:    box_y_q    <= cfg_data;
				CFG_BOX_Z:    box_z_q    <= cfg_data;
				CFG_SMALLEST: smallest_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control counters: clear sweep, found flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			found_q <= 1'b0;
		end else begin
			if (cmd.clr_write) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (cmd.cap_in) begin
				found_q <= 1'b0;
			end else if (cmd.set_found) begin
				found_q <= 1'b1;
			end
		end
	end

	// Capture, cell/reach/scan/index math, list cursor, distance, output
	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			item_q <= in_item;
		end
		if (cmd.calc_cell) begin
			cx_q  <= cell_of(item_q.pos_x, nx);
			cy_q  <= cell_of(item_q.pos_y, ny);
			cz_q  <= cell_of(item_q.pos_z, nz);
			csq_q <= {{LEN_W{1'b0}}, item_q.cutoff_distance}
				* {{LEN_W{1'b0}}, item_q.cutoff_distance};
		end
		if (cmd.reach_init) begin
			k_q    <= '0;
			kmul_q <= '0;
		end else if (cmd.reach_step) begin
			if (sts.reach_done) begin
				reach_q <= shell_cap ? maxshell : k_q + 3'd1;
			end else begin
				k_q    <= k_q + 3'd1;
				kmul_q <= kmul_q + {4'b0000, smallest_q};
			end
		end
		if (cmd.scan_init) begin
			dx_q <= -$signed({1'b0, hx});
			dy_q <= -$signed({1'b0, hy});
			dz_q <= -$signed({1'b0, hz});
		end else if (cmd.advance) begin
			if (dz_q < $signed({1'b0, hz})) begin
				dz_q <= dz_q + 5'sd1;
			end else begin
				dz_q <= -$signed({1'b0, hz});
				if (dy_q < $signed({1'b0, hy})) begin
					dy_q <= dy_q + 5'sd1;
				end else begin
					dy_q <= -$signed({1'b0, hy});
					dx_q <= dx_q + 5'sd1;
				end
			end
		end
		if (cmd.wrap) begin
			wx_q   <= wrap_coord(cx_q, dx_q, nx);
			wy_q   <= wrap_coord(cy_q, dy_q, ny);
			wz_q   <= wrap_coord(cz_q, dz_q, nz);
			cheb_q <= amax <= {1'b0, reach_q};
		end
		if (cmd.lin1) begin
			t_q <= {4'b0000, ly} + {4'b0000, lz} * {4'b0000, ny};
		end
		if (cmd.lin2) begin
			idx_q <= {8'd0, lx} + {8'd0, nx} * {4'd0, t_q};
		end
		if (cmd.cur_load) begin
			cur_q   <= head_rdata[SLOT_W-1:0];
			steps_q <= '0;
		end else if (cmd.cur_next) begin
			cur_q   <= link_rdata[SLOT_W-1:0];
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.node_mul) begin
			mx_s1 <= comp_len(item_q.pos_x, pos_rdata[POS3_W-1:2*POSITION_BITS], box_x_q);
			my_s1 <= comp_len(item_q.pos_y, pos_rdata[2*POSITION_BITS-1:POSITION_BITS],
				box_y_q);
			mz_s1 <= comp_len(item_q.pos_z, pos_rdata[POSITION_BITS-1:0], box_z_q);
		end
		if (cmd.node_sq) begin
			sx_s2 <= {{LEN_W{1'b0}}, mx_s1} * {{LEN_W{1'b0}}, mx_s1};
			sy_s2 <= {{LEN_W{1'b0}}, my_s1} * {{LEN_W{1'b0}}, my_s1};
			sz_s2 <= {{LEN_W{1'b0}}, mz_s1} * {{LEN_W{1'b0}}, mz_s1};
		end
		if (cmd.load_out) begin
			out_q.overlap_found <= found_q && (item_q.opcode == OP_QUERY);
			out_q.done_opcode   <= item_q.opcode;
		end
	end

	// Chebyshev offset and coordinate source for the linear index
	always_comb begin
		amax = off_mag(dx_q);
		if (off_mag(dy_q) > amax) begin
			amax = off_mag(dy_q);
		end
		if (off_mag(dz_q) > amax) begin
			amax = off_mag(dz_q);
		end
		lx = cmd.lin_scan ? wx_q : cx_q;
		ly = cmd.lin_scan ? wy_q : cy_q;
		lz = cmd.lin_scan ? wz_q : cz_q;
	end

	// Head memory: sweep clears, inserts push
	assign head_waddr = cmd.clr_write ? sweep_q : idx_q;
	assign head_wdata = cmd.clr_write ? '0 : {1'b1, item_q.particle_index};

	pclo_ram #(.WIDTH(HEAD_W), .DEPTH(CELL_SLOTS)) u_head_ram (
		.clk   (clk),
		.we    (cmd.clr_write | cmd.ins_write),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.re    (cmd.head_rd),
		.raddr (idx_q),
		.rdata (head_rdata)
	);

	pclo_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_PARTICLES)) u_link_ram (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (item_q.particle_index),
		.wdata (head_rdata),
		.re    (cmd.node_rd),
		.raddr (cur_q),
		.rdata (link_rdata)
	);

	pclo_ram #(.WIDTH(POS3_W), .DEPTH(MAX_PARTICLES)) u_pos_ram (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (item_q.particle_index),
		.wdata ({item_q.pos_x, item_q.pos_y, item_q.pos_z}),
		.re    (cmd.node_rd),
		.raddr (cur_q),
		.rdata (pos_rdata)
	);

	// Distance sum and status
	assign dsq = {2'b00, sx_s2} + {2'b00, sy_s2} + {2'b00, sz_s2};

	always_comb begin
		sts.op         = item_q.opcode;
		sts.sweep_last = sweep_q == CELL_AW'(CELL_SLOTS - 1);
		sts.reach_done = shell_cap || ({4'b0000, item_q.cutoff_distance} <= kmul_q);
		sts.cheb_ok    = cheb_q;
		sts.head_valid = head_rdata[SLOT_W];
		sts.hit        = dsq < {2'b00, csq_q};
		sts.walk_more  = link_rdata[SLOT_W] && (steps_q != SLOT_W'(MAX_PARTICLES - 1));
		sts.scan_last  = (dx_q == $signed({1'b0, hx})) && (dy_q == $signed({1'b0, hy}))
			&& (dz_q == $signed({1'b0, hz}));
	end

	assign out_item = out_q;

endmodule

[design/pclo_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pclo_ctrl
// Controller: sequences clear sweeps, inserts and the cell/list walk of a
// query, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module pclo_ctrl import pclo_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [4:0] ST_INIT     = 5'd0;
	localparam logic [4:0] ST_IDLE     = 5'd1;
	localparam logic [4:0] ST_DEC      = 5'd2;
	localparam logic [4:0] ST_CLR      = 5'd3;
	localparam logic [4:0] ST_INS_CELL = 5'd4;
	localparam logic [4:0] ST_INS_LIN1 = 5'd5;
	localparam logic [4:0] ST_INS_LIN2 = 5'd6;
	localparam logic [4:0] ST_INS_RD   = 5'd7;
	localparam logic [4:0] ST_INS_WR   = 5'd8;
	localparam logic [4:0] ST_Q_CELL   = 5'd9;
	localparam logic [4:0] ST_Q_REACH  = 5'd10;
	localparam logic [4:0] ST_WRAP     = 5'd11;
	localparam logic [4:0] ST_LIN1     = 5'd12;
	localparam logic [4:0] ST_LIN2     = 5'd13;
	localparam logic [4:0] ST_HEAD_RD  = 5'd14;
	localparam logic [4:0] ST_HEAD_CHK = 5'd15;
	localparam logic [4:0] ST_NODE_RD  = 5'd16;
	localparam logic [4:0] ST_NODE_MUL = 5'd17;
	localparam logic [4:0] ST_NODE_SQ  = 5'd18;
	localparam logic [4:0] ST_NODE_CMP = 5'd19;
	localparam logic [4:0] ST_ADV      = 5'd20;
	localparam logic [4:0] ST_FIN      = 5'd21;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_write = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				case (sts.op)
					OP_CLEAR:  state_d = ST_CLR;
					OP_INSERT: state_d = ST_INS_CELL;
					OP_QUERY:  state_d = ST_Q_CELL;
					default:   state_d = ST_FIN;
				endcase
			end
			ST_CLR: begin
				cmd.clr_write = 1'b1;
				if (sts.sweep_last) state_d = ST_FIN;
			end
			ST_INS_CELL: begin
				cmd.calc_cell = 1'b1;
				state_d = ST_INS_LIN1;
			end
			ST_INS_LIN1: begin
				cmd.lin1 = 1'b1;
				state_d = ST_INS_LIN2;
			end
			ST_INS_LIN2: begin
				cmd.lin2 = 1'b1;
				state_d = ST_INS_RD;
			end
			ST_INS_RD: begin
				cmd.head_rd = 1'b1;
				state_d = ST_INS_WR;
			end
			ST_INS_WR: begin
				cmd.ins_write = 1'b1;
				state_d = ST_FIN;
			end
			ST_Q_CELL: begin
				cmd.calc_cell  = 1'b1;
				cmd.reach_init = 1'b1;
				state_d = ST_Q_REACH;
			end
			ST_Q_REACH: begin
				cmd.reach_step = 1'b1;
				if (sts.reach_done) begin
					cmd.scan_init = 1'b1;
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d = ST_LIN1;
			end
			ST_LIN1: begin
				if (sts.cheb_ok) begin
					cmd.lin1     = 1'b1;
					cmd.lin_scan = 1'b1;
					state_d = ST_LIN2;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_LIN2: begin
				cmd.lin2     = 1'b1;
				cmd.lin_scan = 1'b1;
				state_d = ST_HEAD_RD;
			end
			ST_HEAD_RD: begin
				cmd.head_rd = 1'b1;
				state_d = ST_HEAD_CHK;
			end
			ST_HEAD_CHK: begin
				if (sts.head_valid) begin
					cmd.cur_load = 1'b1;
					state_d = ST_NODE_RD;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_NODE_RD: begin
				cmd.node_rd = 1'b1;
				state_d = ST_NODE_MUL;
			end
			ST_NODE_MUL: begin
				cmd.node_mul = 1'b1;
				state_d = ST_NODE_SQ;
			end
			ST_NODE_SQ: begin
				cmd.node_sq = 1'b1;
				state_d = ST_NODE_CMP;
			end
			ST_NODE_CMP: begin
				if (sts.hit) begin
					cmd.set_found = 1'b1;
					state_d = ST_FIN;
				end else if (sts.walk_more) begin
					cmd.cur_next = 1'b1;
					state_d = ST_NODE_RD;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_ADV: begin
				if (sts.scan_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.advance = 1'b1;
					state_d = ST_WRAP;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/periodic_cell_list_overlap_search.sv]
`timescale 1ns / 1ps
// Clear sweeps the head memory, one head entry a cycle. Insert computes the cell and
// index, reads and writes the cell head. Query computes the cell, steps the reach search,
// checks each scan cell, walks the lists of cells in reach; a hit ends the query early.
// Throughput: one item at a time; the list walk through the link and position memories
// sets the query rate. A result waits in an output register while the next beat comes in.
// Reset: after arst_n releases, a sweep empties all cells; no beat is taken during it.
// ----------------------------------------------------------------------------
// periodic_cell_list_overlap_search
// Periodic linked-cell index with clear, insert and overlap query.
// ----------------------------------------------------------------------------
`include "periodic_cell_list_overlap_search_macros.svh"

module periodic_cell_list_overlap_search import pclo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item
);

	cmd_t cmd;
	sts_t sts;

	pclo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pclo_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sts       (sts),
		.out_item  (out_item)
	);

	// Checks
	`PCLO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "beat taken while busy")
	`PCLO_ASSERT_SAME(a_found_only_query, out_valid && out_item.overlap_found, out_item.done_opcode == OP_QUERY, "overlap flagged on non-query")
	`PCLO_ASSERT_SAME(a_load_when_free, cmd.load_out, !out_valid || out_ready, "result overwritten")

endmodule
